// File: sv/rciq_pkg.sv
// ----------------------------------------------------------------------------
// rciq_pkg
// shared types and constants for the reserve/commit in-order queue
// ----------------------------------------------------------------------------
package rciq_pkg;

    localparam int OP_W     = 2;
    localparam int TICKET_W = 5;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE   = 2'd0,
        OP_COMMIT    = 2'd1,
        OP_POP_START = 2'd2,
        OP_POP_CONT  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_CLAIMED   = 3'd4,
        ST_BATCH_END = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } ctrl_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } ctrl_cmd_t;

endpackage

// File: sv/rciq_ctrl.sv
// ----------------------------------------------------------------------------
// rciq_ctrl
// sequencer: capture a transaction, execute it, load the result register
// ----------------------------------------------------------------------------
module rciq_ctrl
    import rciq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        load_ok;

    // result register is free when empty or being drained this cycle
    assign load_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (load_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_LOAD:
            begin
                cmd.load = load_ok;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/rciq_datapath.sv
// ----------------------------------------------------------------------------
// rciq_datapath
// pointers, ready marks, slot memory and result register of the queue
// ----------------------------------------------------------------------------
module rciq_datapath
    import rciq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    input  logic [OP_W-1:0]       operation,
    input  logic [TICKET_W-1:0]   ticket,
    input  logic [DATA_WIDTH-1:0] write_data,
    output logic [STATUS_W-1:0]   status,
    output logic [TICKET_W-1:0]   granted_ticket,
    output logic [DATA_WIDTH-1:0] read_data
);

    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W    = $clog2(2 * DEPTH);
    localparam int OCC_W    = PTR_W + 1;
    localparam int TICKET_N = 2 ** TICKET_W;
    localparam logic [OCC_W-1:0] PTR_MOD = OCC_W'(2 * DEPTH);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * DEPTH - 1);

    // constant ticket-to-slot table
    logic [SLOT_W-1:0] tk_slot_tab [TICKET_N];

    genvar gi;
    generate
        for (gi = 0; gi < TICKET_N; gi++)
        begin : g_tk_tab
            assign tk_slot_tab[gi] = SLOT_W'(gi % DEPTH);
        end
    endgenerate

    function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] d;
        d = (PTR_W'(p) >= PTR_W'(DEPTH)) ? p - PTR_W'(DEPTH) : p;
        return SLOT_W'(d);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    op_t                   op_reg;
    logic [TICKET_W-1:0]   ticket_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;

    logic [PTR_W-1:0]  head_reg,  head_next;
    logic [PTR_W-1:0]  tail_reg,  tail_next;
    logic [PTR_W-1:0]  claim_reg, claim_next;
    logic [DEPTH-1:0]  ready_reg, ready_next;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    status_t             res_status_reg, res_status_next;
    logic [TICKET_W-1:0] res_grant_reg,  res_grant_next;
    logic                res_use_rd_reg, res_use_rd_next;

    status_t               status_reg;
    logic [TICKET_W-1:0]   granted_reg;
    logic [DATA_WIDTH-1:0] read_data_reg;

    logic [OCC_W-1:0]  occ;
    logic              full;
    logic [PTR_W-1:0]  head_inc;
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] nxt_slot;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] tk_slot;
    logic [SLOT_W-1:0] rd_slot;
    logic              mem_we;

    assign occ = (tail_reg >= head_reg)
               ? OCC_W'(tail_reg) - OCC_W'(head_reg)
               : OCC_W'(tail_reg) + PTR_MOD - OCC_W'(head_reg);
    assign full      = (occ >= OCC_FULL);
    assign head_inc  = ptr_inc(head_reg);
    assign head_slot = slot_of(head_reg);
    assign nxt_slot  = slot_of(head_inc);
    assign tail_slot = slot_of(tail_reg);
    assign tk_slot   = tk_slot_tab[ticket_reg];
    assign rd_slot   = (op_reg == OP_POP_START) ? head_slot : nxt_slot;
    assign mem_we    = cmd.exec && (op_reg == OP_COMMIT);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        claim_next      = claim_reg;
        ready_next      = ready_reg;
        res_status_next = ST_OK;
        res_grant_next  = '0;
        res_use_rd_next = 1'b0;
        unique case (op_reg)
            OP_RESERVE:
            begin
                if (full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ready_next[tail_slot] = 1'b0;
                    res_grant_next        = TICKET_W'(tail_reg);
                    tail_next             = ptr_inc(tail_reg);
                end
            end
            OP_COMMIT:
            begin
                ready_next[tk_slot] = 1'b1;
            end
            OP_POP_START:
            begin
                priority if (head_reg == tail_reg)
                begin
                    res_status_next = ST_EMPTY;
                end
                else if (!ready_reg[head_slot])
                begin
                    res_status_next = ST_NOT_READY;
                end
                else if (claim_reg != head_reg)
                begin
                    res_status_next = ST_CLAIMED;
                end
                else
                begin
                    res_use_rd_next = 1'b1;
                    claim_next      = head_inc;
                end
            end
            OP_POP_CONT:
            begin
                if (head_inc != tail_reg && ready_reg[nxt_slot] && claim_reg != tail_reg)
                begin
                    res_use_rd_next = 1'b1;
                    claim_next      = ptr_inc(claim_reg);
                end
                else
                begin
                    res_status_next = ST_BATCH_END;
                end
                head_next = head_inc;
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    // input capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_t'(operation);
            ticket_reg <= ticket;
            wdata_reg  <= write_data;
        end
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_grant_reg  <= res_grant_next;
            res_use_rd_reg <= res_use_rd_next;
        end
        if (cmd.load)
        begin
            status_reg    <= res_status_reg;
            granted_reg   <= res_grant_reg;
            read_data_reg <= res_use_rd_reg ? rd_data_reg : '0;
        end
    end

    // slot memory, at most one write and one registered read per transaction
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[tk_slot] <= wdata_reg;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            claim_reg <= '0;
            ready_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            claim_reg <= claim_next;
            ready_reg <= ready_next;
        end
    end

    assign status         = status_reg;
    assign granted_ticket = granted_reg;
    assign read_data      = read_data_reg;

endmodule

// File: sv/reserve_commit_inorder_queue.sv
// ----------------------------------------------------------------------------
// reserve_commit_inorder_queue
// ring queue: slots reserved in order, committed out of order, drained in order
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) carries one operation per transaction:
// reserve, commit (ticket + write_data), pop start or pop continue.
// output channel (out_valid/out_ready) returns one result per transaction:
// status, granted_ticket (successful reserve) and read_data (successful pop).
// each transaction passes through capture, execute (pointer update, a slot
// memory write on commit and a registered read), then load into the result
// register; a new transaction is taken only after the previous one is loaded.
// out_valid rises as the result is loaded into the result register.
// the result register is separate, so a new transaction is captured while the
// previous result waits; a stalled receiver holds the block in its load step
// until the result register frees up, and in_ready stays low meanwhile.
// reset clears the head, tail and claim pointers and all ready marks; the
// slot data memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module reserve_commit_inorder_queue
    import rciq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic [TICKET_W-1:0]   ticket,
    input  logic [DATA_WIDTH-1:0] write_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [TICKET_W-1:0]   granted_ticket,
    output logic [DATA_WIDTH-1:0] read_data
);

    ctrl_cmd_t cmd;

    rciq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rciq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .operation      (operation),
        .ticket         (ticket),
        .write_data     (write_data),
        .status         (status),
        .granted_ticket (granted_ticket),
        .read_data      (read_data)
    );

endmodule

// File: sim/rciq_result_checker.sv
// ----------------------------------------------------------------------------
// rciq_result_checker
// watches both channels of the reserve/commit queue, predicts each result
// from a mirror of the ring and compares it field by field
// ----------------------------------------------------------------------------
module rciq_result_checker
    import rciq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [TICKET_W-1:0] ticket,
    input  logic [DATA_W-1:0]   write_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [TICKET_W-1:0] granted_ticket,
    input  logic [DATA_W-1:0]   read_data,
    output int                  errors,
    output int                  pending
);

    localparam int PTR_W  = $clog2(2 * DEPTH);
    localparam int SLOT_W = $clog2(DEPTH);

    typedef struct packed {
        status_t               status;
        logic [TICKET_W-1:0]   granted;
        logic [DATA_W-1:0]     rdata;
    } queue_result_t;

    logic [DEPTH-1:0]  mirror_ready;
    logic [DATA_W-1:0] mirror_data [DEPTH];
    logic [PTR_W-1:0]  mirror_head;
    logic [PTR_W-1:0]  mirror_tail;
    logic [PTR_W-1:0]  mirror_claim;

    queue_result_t awaited_results [$];
    queue_result_t predicted;
    queue_result_t oldest;

    // advances the mirrored ring by one operation and returns its result
    task automatic apply_queue_op(
        input  op_t                 op,
        input  logic [TICKET_W-1:0] tk,
        input  logic [DATA_W-1:0]   wd,
        output queue_result_t       res
    );
        logic [PTR_W-1:0] nxt;
        res.status  = ST_OK;
        res.granted = '0;
        res.rdata   = '0;
        nxt = mirror_head + 1'b1;
        case (op)
            OP_RESERVE:
            begin
                if (PTR_W'(mirror_tail - mirror_head) < DEPTH)
                begin
                    mirror_ready[mirror_tail[SLOT_W-1:0]] = 1'b0;
                    mirror_data[mirror_tail[SLOT_W-1:0]]  = '0;
                    res.granted = TICKET_W'(mirror_tail);
                    mirror_tail = mirror_tail + 1'b1;
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            OP_COMMIT:
            begin
                mirror_data[tk[SLOT_W-1:0]]  = wd;
                mirror_ready[tk[SLOT_W-1:0]] = 1'b1;
            end
            OP_POP_START:
            begin
                if (mirror_head == mirror_tail)
                    res.status = ST_EMPTY;
                else if (!mirror_ready[mirror_head[SLOT_W-1:0]])
                    res.status = ST_NOT_READY;
                else if (mirror_claim != mirror_head)
                    res.status = ST_CLAIMED;
                else
                begin
                    res.rdata    = mirror_data[mirror_head[SLOT_W-1:0]];
                    mirror_claim = nxt;
                end
            end
            OP_POP_CONT:
            begin
                // the head moves on whether or not the next entry is handed over
                if (nxt != mirror_tail && mirror_ready[nxt[SLOT_W-1:0]]
                    && mirror_claim != mirror_tail)
                begin
                    res.rdata    = mirror_data[nxt[SLOT_W-1:0]];
                    mirror_claim = mirror_claim + 1'b1;
                end
                else
                begin
                    res.status = ST_BATCH_END;
                end
                mirror_head = nxt;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_ready = '0;
            for (int i = 0; i < DEPTH; i++)
                mirror_data[i] = '0;
            mirror_head  = '0;
            mirror_tail  = '0;
            mirror_claim = '0;
            awaited_results.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_queue_op(op_t'(operation), ticket, write_data, predicted);
                awaited_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with nothing awaited");
                    errors++;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (status != oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, status);
                        errors++;
                    end
                    if (granted_ticket != oldest.granted)
                    begin
                        $error("granted_ticket: expected %0d, got %0d",
                               oldest.granted, granted_ticket);
                        errors++;
                    end
                    if (read_data != oldest.rdata)
                    begin
                        $error("read_data: expected %h, got %h", oldest.rdata, read_data);
                        errors++;
                    end
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

// File: sim/tb_reserve_commit_inorder_queue.sv
// ----------------------------------------------------------------------------
// tb_reserve_commit_inorder_queue
// drives reserve, commit and pop transactions into the in-order queue with
// random gaps on both channels; a separate checker predicts and compares
// ----------------------------------------------------------------------------
module tb_reserve_commit_inorder_queue;
    import rciq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DATA_W      = 64;
    localparam int PTR_W       = $clog2(2 * DEPTH);
    localparam int SLOT_W      = $clog2(DEPTH);
    localparam int ITEM_COUNT  = 1300;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 20;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     operation;
    logic [TICKET_W-1:0] ticket;
    logic [DATA_W-1:0]   write_data;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] granted_ticket;
    logic [DATA_W-1:0]   read_data;
    int                  errors;
    int                  pending;

    // pointer shadow used only to steer the stimulus towards sensible sequences
    logic [DEPTH-1:0] plan_ready = '0;
    logic [PTR_W-1:0] plan_head  = '0;
    logic [PTR_W-1:0] plan_tail  = '0;
    logic [PTR_W-1:0] plan_claim = '0;
    int               items_sent = 0;
    bit               send_quiet = 1'b0;
    bit               recv_quiet = 1'b0;

    reserve_commit_inorder_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .ticket         (ticket),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_ticket (granted_ticket),
        .read_data      (read_data)
    );

    rciq_result_checker #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .ticket         (ticket),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_ticket (granted_ticket),
        .read_data      (read_data),
        .errors         (errors),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [PTR_W-1:0] plan_occupancy();
        return PTR_W'(plan_tail - plan_head);
    endfunction

    task automatic plan_apply(input op_t op, input logic [TICKET_W-1:0] tk);
        logic [PTR_W-1:0] nxt;
        nxt = plan_head + 1'b1;
        case (op)
            OP_RESERVE:
            begin
                if (plan_occupancy() < DEPTH)
                begin
                    plan_ready[plan_tail[SLOT_W-1:0]] = 1'b0;
                    plan_tail = plan_tail + 1'b1;
                end
            end
            OP_COMMIT:
                plan_ready[tk[SLOT_W-1:0]] = 1'b1;
            OP_POP_START:
            begin
                if (plan_head != plan_tail && plan_ready[plan_head[SLOT_W-1:0]]
                    && plan_claim == plan_head)
                    plan_claim = nxt;
            end
            OP_POP_CONT:
            begin
                if (nxt != plan_tail && plan_ready[nxt[SLOT_W-1:0]] && plan_claim != plan_tail)
                    plan_claim = plan_claim + 1'b1;
                plan_head = nxt;
            end
        endcase
    endtask

    // one input transaction; entered and left at a falling edge
    task automatic issue(input op_t op, input logic [TICKET_W-1:0] tk,
                         input logic [DATA_W-1:0] wd);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        ticket     <= tk;
        write_data <= wd;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        plan_apply(op, tk);
        items_sent++;
    endtask

    task automatic issue_bare(input op_t op);
        issue(op, TICKET_W'($urandom_range(0, 31)), pick_data());
    endtask

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int gap;
        int results;
        results   = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (results == HOLD_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 29) == 0)
                recv_quiet = !recv_quiet;
            gap = recv_quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            results++;
        end
    end

    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int               choice;
        int               n;
        int               room;
        int               m;
        int               k;
        int               idx;
        logic [PTR_W-1:0] occ;
        logic [PTR_W-1:0] tk;
        logic [PTR_W-1:0] held [$];

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_RESERVE;
        ticket     = '0;
        write_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed opening: empty, not ready, out-of-order commit, claimed,
        // batch end, overwrite, stray commit, head run past tail, full
        issue_bare(OP_POP_START);
        issue_bare(OP_RESERVE);
        issue_bare(OP_RESERVE);
        issue_bare(OP_RESERVE);
        issue_bare(OP_POP_START);
        issue(OP_COMMIT, 5'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(OP_COMMIT, 5'd16, 64'h0);
        issue_bare(OP_POP_START);
        issue_bare(OP_POP_START);
        issue_bare(OP_POP_CONT);
        issue(OP_COMMIT, 5'd1, 64'h8000_0000_0000_0001);
        issue(OP_COMMIT, 5'd1, 64'hA5A5_A5A5_5A5A_5A5A);
        issue_bare(OP_POP_START);
        issue_bare(OP_POP_CONT);
        issue_bare(OP_POP_CONT);
        issue(OP_COMMIT, 5'd31, pick_data());
        issue_bare(OP_POP_CONT);
        issue_bare(OP_RESERVE);
        issue_bare(OP_POP_START);

        while (items_sent < ITEM_COUNT)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 72)
            begin
                // bring odd pointer states back to an aligned, empty ring first
                occ = plan_occupancy();
                if (occ > DEPTH || (plan_claim != plan_head
                                    && plan_claim != PTR_W'(plan_head + 1'b1)))
                begin
                    repeat (occ) issue_bare(OP_POP_CONT);
                    while (plan_claim != plan_head)
                    begin
                        k = PTR_W'(plan_claim - plan_head);
                        if (k > DEPTH)
                            k = DEPTH;
                        repeat (k) issue_bare(OP_RESERVE);
                        repeat (k) issue_bare(OP_POP_CONT);
                    end
                end

                room = DEPTH - plan_occupancy();
                n = (room == 0 || $urandom_range(0, 5) == 0) ? room + 1
                                                             : $urandom_range(1, room);
                repeat (n)
                begin
                    if (plan_occupancy() < DEPTH)
                        held.push_back(plan_tail);
                    issue_bare(OP_RESERVE);
                end

                // commits in shuffled order, some skipped, early pops mixed in
                while (held.size() > 0)
                begin
                    idx = $urandom_range(0, held.size() - 1);
                    tk  = held[idx];
                    held.delete(idx);
                    if ($urandom_range(0, 3) == 0)
                        tk[PTR_W-1] = ~tk[PTR_W-1];
                    if ($urandom_range(0, 9) == 0)
                        issue_bare(OP_POP_START);
                    if ($urandom_range(0, 11) != 0)
                        issue(OP_COMMIT, tk, pick_data());
                end

                issue_bare(OP_POP_START);
                occ = plan_occupancy();
                m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, occ) : occ;
                repeat (m) issue_bare(OP_POP_CONT);
            end
            else if (choice < 94)
            begin
                repeat ($urandom_range(1, 6))
                    issue(op_t'($urandom_range(0, 3)), TICKET_W'($urandom_range(0, 31)),
                          pick_data());
            end
            else
            begin
                // head laps the whole pointer space; reserves meet a bogus full ring
                repeat (2 * DEPTH)
                begin
                    if (plan_occupancy() >= DEPTH && $urandom_range(0, 5) == 0)
                        issue_bare(OP_RESERVE);
                    issue_bare(OP_POP_CONT);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
